// ===== sv/lowest_free_label_allocator_assert.svh =====
// Assertion macros for the lowest free label allocator.
`ifndef LOWEST_FREE_LABEL_ALLOCATOR_ASSERT_SVH
`define LOWEST_FREE_LABEL_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LFLA_ASSERT_NOW(name, clk, rst, cond, conseq, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define LFLA_ASSERT_NEXT(name, clk, rst, cond, conseq, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);

`endif

// ===== sv/lfla_pkg.sv =====
// Shared types, constants and codes of the lowest free label allocator.
package lfla_pkg;

   localparam int LABEL_COUNT = 4096;
   localparam int WORD_BITS   = 64;
   localparam int LABEL_W     = 12;
   localparam int LABEL_FLOOR = 'h10;
   localparam int NWORDS      = (LABEL_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int BIT_W       = $clog2(WORD_BITS);
   localparam int ADDR_W      = $clog2(NWORDS);

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
   localparam logic [1:0] STATUS_NOT_USED  = 2'd2;

   localparam logic CSR_MIN_LABEL = 1'b0;
   localparam logic CSR_MAX_LABEL = 1'b1;

   typedef struct packed {
      logic [1:0]         op;
      logic [LABEL_W-1:0] label_in;
   } req_type;

   typedef struct packed {
      logic [LABEL_W-1:0] label_out;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic       load_req;
      logic       rd_en;
      logic       next_word;
      logic       wr_en;
      logic       clear_all;
      logic       load_rsp;
      logic [1:0] status;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       cand_ok;
      logic       free_ok;
      logic       hit;
      logic       last_word;
   } sts_type;

endpackage

// ===== sv/lfla_dp.sv =====
// Datapath: window registers, bitmap memory, full-word summary and result register.
module lfla_dp
   import lfla_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  req_type            req_data,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [LABEL_W-1:0] csr_wr_data,
   output rsp_type            rsp_data
);

   logic [WORD_BITS-1:0] mem [NWORDS];

   logic [LABEL_W-1:0]   min_ff, max_ff;
   logic [1:0]           op_ff;
   logic [LABEL_W-1:0]   label_ff;
   logic [ADDR_W-1:0]    w_ff, w_in;
   logic [ADDR_W-1:0]    word_ff;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_vld_ff;
   logic [NWORDS-1:0]    row_vld_ff;
   logic [NWORDS-1:0]    summary_ff;
   logic [LABEL_W-1:0]   res_label_ff, res_label_in;
   rsp_type              rsp_data_ff;

   logic [LABEL_W-1:0]   lo, hi;
   logic                 win_ok;
   logic [ADDR_W-1:0]    wlo, whi;
   logic [NWORDS-1:0]    avail;
   logic [ADDR_W-1:0]    cand;
   logic [ADDR_W-1:0]    rd_addr;
   logic [WORD_BITS-1:0] word, lo_mask, hi_mask, free_vec, new_word;
   logic [BIT_W-1:0]     free_bit;
   logic                 free_in_win;

   always_comb begin
      lo     = (min_ff < LABEL_W'(LABEL_FLOOR)) ? LABEL_W'(LABEL_FLOOR) : min_ff;
      hi     = (max_ff > LABEL_W'(LABEL_COUNT - 1)) ? LABEL_W'(LABEL_COUNT - 1) : max_ff;
      win_ok = lo <= hi;
      wlo    = lo[LABEL_W-1:BIT_W];
      whi    = hi[LABEL_W-1:BIT_W];
   end

   always_comb begin
      avail = ~summary_ff & ({NWORDS{1'b1}} << w_ff);
      cand  = '0;
      for (int i = NWORDS - 1; i >= 0; i--) begin
         if (avail[i]) begin
            cand = ADDR_W'(i);
         end
      end
   end

   always_comb begin
      word     = rd_vld_ff ? rd_data_ff : '0;
      lo_mask  = (word_ff == wlo) ? ({WORD_BITS{1'b1}} << lo[BIT_W-1:0]) : '1;
      hi_mask  = (word_ff == whi) ?
                 ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi[BIT_W-1:0])) : '1;
      free_vec = ~word & lo_mask & hi_mask;
      free_bit = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (free_vec[i]) begin
            free_bit = BIT_W'(i);
         end
      end
   end

   always_comb begin
      free_in_win = win_ok && (label_ff >= lo) && (label_ff <= hi);
      rd_addr     = (op_ff == OP_FREE) ? label_ff[LABEL_W-1:BIT_W] : cand;
      if (op_ff == OP_FREE) begin
         new_word = word & ~(WORD_BITS'(1) << label_ff[BIT_W-1:0]);
      end else begin
         new_word = word | (WORD_BITS'(1) << free_bit);
      end
   end

   always_comb begin
      sts.op        = op_ff;
      sts.cand_ok   = win_ok && (|avail) && (cand <= whi);
      sts.free_ok   = free_in_win;
      sts.hit       = (op_ff == OP_FREE) ? word[label_ff[BIT_W-1:0]] : (|free_vec);
      sts.last_word = word_ff >= whi;
   end

   always_comb begin
      w_in = w_ff;
      if (cmd.load_req) begin
         w_in = wlo;
      end else if (cmd.next_word) begin
         w_in = word_ff + ADDR_W'(1);
      end
      res_label_in = res_label_ff;
      if (cmd.load_req) begin
         res_label_in = '0;
      end else if (cmd.wr_en && op_ff != OP_FREE) begin
         res_label_in = {word_ff, free_bit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff     <= LABEL_W'(16);
         max_ff     <= LABEL_W'(4095);
         row_vld_ff <= '0;
         summary_ff <= '0;
      end else begin
         if (csr_wr_en && csr_index == CSR_MIN_LABEL) begin
            min_ff <= csr_wr_data;
         end
         if (csr_wr_en && csr_index == CSR_MAX_LABEL) begin
            max_ff <= csr_wr_data;
         end
         if (cmd.clear_all) begin
            row_vld_ff <= '0;
            summary_ff <= '0;
         end else if (cmd.wr_en) begin
            row_vld_ff[word_ff] <= 1'b1;
            summary_ff[word_ff] <= &new_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[word_ff] <= new_word;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_vld_ff  <= row_vld_ff[rd_addr];
         word_ff    <= rd_addr;
      end
      if (cmd.load_req) begin
         op_ff    <= req_data.op;
         label_ff <= req_data.label_in;
      end
      if (cmd.load_rsp) begin
         rsp_data_ff.label_out <= res_label_ff;
         rsp_data_ff.status    <= cmd.status;
      end
      w_ff         <= w_in;
      res_label_ff <= res_label_in;
   end

   assign rsp_data = rsp_data_ff;

endmodule

// ===== sv/lfla_ctrl.sv =====
// Controller: sequences accept, word search, read-modify-write and result hand-off.
`include "lowest_free_label_allocator_assert.svh"
module lfla_ctrl
   import lfla_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_LOOK   = 2'd1;
   localparam logic [1:0] S_CHECK  = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [1:0] status_ff, status_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      cmd       = '0;
      cmd.status = status_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_LOOK;
            end
         end
         S_LOOK: begin
            case (sts.op)
               OP_ALLOC: begin
                  if (sts.cand_ok) begin
                     cmd.rd_en = 1'b1;
                     state_in  = S_CHECK;
                  end else begin
                     status_in = STATUS_EXHAUSTED;
                     state_in  = S_FINISH;
                  end
               end
               OP_FREE: begin
                  if (sts.free_ok) begin
                     cmd.rd_en = 1'b1;
                     state_in  = S_CHECK;
                  end else begin
                     status_in = STATUS_NOT_USED;
                     state_in  = S_FINISH;
                  end
               end
               OP_CLEAR: begin
                  cmd.clear_all = 1'b1;
                  status_in     = STATUS_OK;
                  state_in      = S_FINISH;
               end
               default: begin
                  status_in = STATUS_OK;
                  state_in  = S_FINISH;
               end
            endcase
         end
         S_CHECK: begin
            if (sts.hit) begin
               cmd.wr_en = 1'b1;
               status_in = STATUS_OK;
               state_in  = S_FINISH;
            end else if (sts.op == OP_FREE) begin
               status_in = STATUS_NOT_USED;
               state_in  = S_FINISH;
            end else if (sts.last_word) begin
               status_in = STATUS_EXHAUSTED;
               state_in  = S_FINISH;
            end else begin
               cmd.next_word = 1'b1;
               state_in      = S_LOOK;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         status_ff    <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   `LFLA_ASSERT_NEXT(a_accept_to_look, clock, reset, req_valid && !req_stall,
                     state_ff == S_LOOK, "accepted item did not start a search")
   `LFLA_ASSERT_NOW(a_write_on_hit, clock, reset, cmd.wr_en,
                    sts.hit && state_ff == S_CHECK, "bitmap write without a hit")
   `LFLA_ASSERT_NEXT(a_rsp_loaded, clock, reset, cmd.load_rsp,
                     rsp_valid_ff && state_ff == S_IDLE, "result not presented")

endmodule

// ===== sv/lowest_free_label_allocator.sv =====
// Sequence: from accept, an allocate or an in-window free passes the look, check and finish
// states before its result is registered; an allocate that reads a second bitmap word (at
// most one extra) passes look and check once more. An empty search, an out-of-window free,
// clear and unused codes go from look straight to finish. Flow: one item at a time, plus
// result stalls; the next item is taken the cycle after the result is registered.
// Reset: synchronous; clears per-word valid flags and the full-word summary at once,
// so the bitmap reads as all free with no sweep; window returns to 16..4095.
module lowest_free_label_allocator
   import lfla_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [LABEL_W-1:0] csr_wr_data
);

   cmd_type cmd;
   sts_type sts;

   lfla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lfla_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== sim/tb_lowest_free_label_allocator.sv =====
// Self-checking testbench for the lowest free label allocator: directed table, then random items.
`timescale 1ns / 1ps

module tb_lowest_free_label_allocator;
   import lfla_pkg::*;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         CYCLE_LIMIT = 1_000_000;
   localparam int         PHASES      = 10;
   localparam int         PHASE_ITEMS = 108;
   localparam int         ROWS        = 29;

   typedef enum logic {ROW_ITEM, ROW_WINDOW} row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      logic [1:0]         op;
      logic [LABEL_W-1:0] arg_a;
      logic [LABEL_W-1:0] arg_b;
      logic [LABEL_W-1:0] exp_label;
      logic [1:0]         exp_status;
   } directed_row_type;

   logic               clock;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   req_type            req_data    = '0;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   rsp_type            rsp_data;
   logic               csr_wr_en   = 1'b0;
   logic               csr_index   = CSR_MIN_LABEL;
   logic [LABEL_W-1:0] csr_wr_data = '0;

   logic [LABEL_COUNT-1:0] label_in_use = '0;
   logic [LABEL_W-1:0]     window_min   = 12'd16;
   logic [LABEL_W-1:0]     window_max   = 12'd4095;
   logic [LABEL_W-1:0]     granted_labels[$];
   rsp_type                pending_rsps[$];
   rsp_type                expected;
   logic                   calm_period  = 1'b0;
   logic                   alloc_heavy  = 1'b0;
   int                     error_count  = 0;
   int                     cycle_count  = 0;

   directed_row_type directed_rows [ROWS] = '{
      '{ROW_ITEM,   OP_FREE,   12'd16,   12'd0,    12'd0,    STATUS_NOT_USED},
      '{ROW_ITEM,   OP_ALLOC,  12'd0,    12'd0,    12'd16,   STATUS_OK},
      '{ROW_ITEM,   OP_ALLOC,  12'd4095, 12'd0,    12'd17,   STATUS_OK},
      '{ROW_ITEM,   OP_FREE,   12'd16,   12'd0,    12'd0,    STATUS_OK},
      '{ROW_ITEM,   OP_ALLOC,  12'd0,    12'd0,    12'd16,   STATUS_OK},
      '{ROW_ITEM,   OP_FREE,   12'd4095, 12'd0,    12'd0,    STATUS_NOT_USED},
      '{ROW_ITEM,   OP_FREE,   12'd0,    12'd0,    12'd0,    STATUS_NOT_USED},
      '{ROW_ITEM,   OP_FREE,   12'd15,   12'd0,    12'd0,    STATUS_NOT_USED},
      '{ROW_ITEM,   OP_UNUSED, 12'd4095, 12'd0,    12'd0,    STATUS_OK},
      '{ROW_ITEM,   OP_CLEAR,  12'd0,    12'd0,    12'd0,    STATUS_OK},
      '{ROW_ITEM,   OP_FREE,   12'd17,   12'd0,    12'd0,    STATUS_NOT_USED},
      '{ROW_ITEM,   OP_ALLOC,  12'd0,    12'd0,    12'd16,   STATUS_OK},
      '{ROW_WINDOW, OP_ALLOC,  12'd4094, 12'd4095, 12'd0,    STATUS_OK},
      '{ROW_ITEM,   OP_ALLOC,  12'd0,    12'd0,    12'd4094, STATUS_OK},
      '{ROW_ITEM,   OP_ALLOC,  12'd0,    12'd0,    12'd4095, STATUS_OK},
      '{ROW_ITEM,   OP_ALLOC,  12'd0,    12'd0,    12'd0,    STATUS_EXHAUSTED},
      '{ROW_ITEM,   OP_FREE,   12'd4095, 12'd0,    12'd0,    STATUS_OK},
      '{ROW_ITEM,   OP_ALLOC,  12'd0,    12'd0,    12'd4095, STATUS_OK},
      '{ROW_ITEM,   OP_FREE,   12'd16,   12'd0,    12'd0,    STATUS_NOT_USED},
      '{ROW_WINDOW, OP_ALLOC,  12'd0,    12'd17,   12'd0,    STATUS_OK},
      '{ROW_ITEM,   OP_ALLOC,  12'd0,    12'd0,    12'd17,   STATUS_OK},
      '{ROW_ITEM,   OP_ALLOC,  12'd0,    12'd0,    12'd0,    STATUS_EXHAUSTED},
      '{ROW_ITEM,   OP_FREE,   12'd16,   12'd0,    12'd0,    STATUS_OK},
      '{ROW_WINDOW, OP_ALLOC,  12'd4095, 12'd15,   12'd0,    STATUS_OK},
      '{ROW_ITEM,   OP_ALLOC,  12'd0,    12'd0,    12'd0,    STATUS_EXHAUSTED},
      '{ROW_ITEM,   OP_FREE,   12'd17,   12'd0,    12'd0,    STATUS_NOT_USED},
      '{ROW_WINDOW, OP_ALLOC,  12'd16,   12'd4095, 12'd0,    STATUS_OK},
      '{ROW_ITEM,   OP_CLEAR,  12'd0,    12'd0,    12'd0,    STATUS_OK},
      '{ROW_ITEM,   OP_ALLOC,  12'd0,    12'd0,    12'd16,   STATUS_OK}
   };

   lowest_free_label_allocator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int effective_low();
      return (window_min < LABEL_FLOOR) ? LABEL_FLOOR : int'(window_min);
   endfunction

   function automatic int effective_high();
      return (window_max > LABEL_COUNT - 1) ? LABEL_COUNT - 1 : int'(window_max);
   endfunction

   function automatic rsp_type predict_label_op(req_type item);
      rsp_type rsp;
      int      lo;
      int      hi;
      int      l;
      lo  = effective_low();
      hi  = effective_high();
      rsp = '{label_out: '0, status: STATUS_OK};
      case (item.op)
         OP_ALLOC: begin
            rsp.status = STATUS_EXHAUSTED;
            for (l = lo; l <= hi; l++) begin
               if (!label_in_use[l]) begin
                  label_in_use[l] = 1'b1;
                  granted_labels.push_back(LABEL_W'(l));
                  rsp.label_out = LABEL_W'(l);
                  rsp.status    = STATUS_OK;
                  break;
               end
            end
         end
         OP_FREE: begin
            if (lo <= hi && item.label_in >= lo && item.label_in <= hi
                && label_in_use[item.label_in]) begin
               label_in_use[item.label_in] = 1'b0;
               for (l = 0; l < granted_labels.size(); l++) begin
                  if (granted_labels[l] == item.label_in) begin
                     granted_labels.delete(l);
                     break;
                  end
               end
            end else begin
               rsp.status = STATUS_NOT_USED;
            end
         end
         OP_CLEAR: begin
            label_in_use = '0;
            granted_labels.delete();
         end
         default: begin
         end
      endcase
      return rsp;
   endfunction

   function automatic req_type random_label_request();
      req_type item;
      int      roll;
      int      lo;
      int      hi;
      lo            = effective_low();
      hi            = effective_high();
      roll          = $urandom_range(99);
      item.op       = OP_ALLOC;
      item.label_in = LABEL_W'($urandom_range(LABEL_COUNT - 1));
      if (alloc_heavy) begin
         if (roll >= 85 && roll < 95 && granted_labels.size() != 0) begin
            item.op       = OP_FREE;
            item.label_in = granted_labels[$urandom_range(granted_labels.size() - 1)];
         end else if (roll >= 95 && roll < 98) begin
            item.op = OP_FREE;
         end else if (roll >= 98) begin
            item.op = OP_UNUSED;
         end
      end else if (roll >= 50 && roll < 78 && granted_labels.size() != 0) begin
         item.op       = OP_FREE;
         item.label_in = granted_labels[$urandom_range(granted_labels.size() - 1)];
      end else if (roll >= 78 && roll < 83) begin
         item.op = OP_FREE;
      end else if (roll >= 83 && roll < 88) begin
         item.op = OP_FREE;
         if (lo <= hi)
            item.label_in = LABEL_W'($urandom_range(hi, lo));
      end else if (roll >= 88 && roll < 93) begin
         item.op = OP_CLEAR;
      end else if (roll >= 93 && roll < 96) begin
         item.op = OP_UNUSED;
      end
      return item;
   endfunction

   task automatic send_request(input req_type item, input logic use_typed,
                               input rsp_type typed_rsp);
      rsp_type predicted;
      if (!calm_period && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 8);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      predicted = predict_label_op(item);
      pending_rsps.push_back(use_typed ? typed_rsp : predicted);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0)
         @(posedge clock);
   endtask

   task automatic program_window(input logic [LABEL_W-1:0] lo, input logic [LABEL_W-1:0] hi);
      wait_for_results();
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_MIN_LABEL;
      csr_wr_data <= lo;
      @(posedge clock);
      window_min  = lo;
      csr_index   <= CSR_MAX_LABEL;
      csr_wr_data <= hi;
      @(posedge clock);
      window_max  = hi;
      csr_wr_en   <= 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_stall <= !calm_period && ($urandom_range(99) < 8);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsps.size() == 0) begin
            $error("unexpected item: label_out %0d status %0d",
                   rsp_data.label_out, rsp_data.status);
            error_count++;
         end else begin
            expected = pending_rsps.pop_front();
            if (rsp_data.label_out !== expected.label_out) begin
               $error("label_out: expected %0d, got %0d", expected.label_out,
                      rsp_data.label_out);
               error_count++;
            end
            if (rsp_data.status !== expected.status) begin
               $error("status: expected %0d, got %0d", expected.status, rsp_data.status);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int                 row;
      int                 phase;
      int                 n;
      int                 lo;
      logic [LABEL_W-1:0] phase_min;
      logic [LABEL_W-1:0] phase_max;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < ROWS; row++) begin
         if (directed_rows[row].kind == ROW_WINDOW)
            program_window(directed_rows[row].arg_a, directed_rows[row].arg_b);
         else
            send_request('{op: directed_rows[row].op, label_in: directed_rows[row].arg_a},
                         1'b1, '{label_out: directed_rows[row].exp_label,
                                 status: directed_rows[row].exp_status});
      end

      for (phase = 0; phase < PHASES; phase++) begin
         lo = $urandom_range(4000, 16);
         case (phase)
            0:       begin phase_min = 12'd16;   phase_max = 12'd4095; end
            1:       begin phase_min = 12'd64;   phase_max = 12'd127;  end
            2:       begin phase_min = 12'd100;  phase_max = 12'd163;  end
            3:       begin phase_min = 12'd4032; phase_max = 12'd4095; end
            4:       begin phase_min = 12'd0;    phase_max = 12'd300;  end
            5:       begin phase_min = 12'd16;   phase_max = 12'd17;   end
            6:       begin phase_min = 12'd2000; phase_max = 12'd1999; end
            9:       begin phase_min = 12'd16;   phase_max = 12'd4095; end
            default: begin
               phase_min = LABEL_W'(lo);
               phase_max = LABEL_W'(lo + $urandom_range(95, 1));
            end
         endcase
         program_window(phase_min, phase_max);
         alloc_heavy = (phase inside {1, 2, 3, 5, 7});
         calm_period = (phase == 4);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 2 && n == 60)
               wait_for_results();
            send_request(random_label_request(), 1'b0, '0);
         end
      end
      calm_period = 1'b0;

      wait_for_results();
      repeat (200) @(posedge clock);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
